// ----- sv/rrnh_pkg.sv -----
// shared types, widths and codes for the ray rectangle nearest hit unit
// no dependencies; imported by the controller, datapath and top level
`default_nettype none

package rrnh_pkg;

   localparam int COORD_W = 24;              // signed Q16.8 coordinate
   localparam int DIFF_W = COORD_W + 1;      // coordinate difference
   localparam int PROD_W = 2 * DIFF_W;       // product of two differences
   localparam int WIDE_W = PROD_W + 1;       // difference of two products
   localparam int TLO_W = WIDE_W / 2;        // low part of split multiply
   localparam int THI_W = WIDE_W - TLO_W;    // high part of split multiply
   localparam int NUM_W = WIDE_W + DIFF_W;   // dividend t * |d|
   localparam int QUO_W = DIFF_W;            // quotient bits
   localparam int RAD_W = 2 * (PROD_W / 2 + 1); // radicand, even bit count
   localparam int ROOT_W = RAD_W / 2;
   localparam int SREM_W = ROOT_W + 2;
   localparam int ID_W = 10;
   localparam int LEN_W = 24;
   localparam int CNT_W = 5;
   localparam int DIV_STEPS = QUO_W;
   localparam int SQRT_STEPS = ROOT_W;

   // beat layouts
   localparam int REQ_DATA_W = 208;
   localparam int REQ_USER_W = 2;
   localparam int RSP_DATA_W = 88;
   localparam int RSP_USER_W = 2;
   localparam int CSR_IDX_W = 2;

   localparam logic signed [COORD_W-1:0] THROUGH_X_RESET = 24'sd2560;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_ORIGIN_X,
      REG_ORIGIN_Y,
      REG_THROUGH_X,
      REG_THROUGH_Y
   } csr_reg_type;

   typedef enum logic [3:0] {
      OP_NONE,
      OP_LOAD,
      OP_EDGE,
      OP_MUL,
      OP_DEN,
      OP_CHECK,
      OP_PMUL,
      OP_PSUM,
      OP_DIV,
      OP_POINT,
      OP_MAG,
      OP_SQR,
      OP_SQSUM,
      OP_SQRT,
      OP_UPDATE,
      OP_RESULT
   } op_type;

   typedef struct packed {
      op_type     op;
      logic [1:0] edge_sel;
      logic       axis;
   } cmd_type;

   typedef struct packed {
      logic solid;
      logic edge_ok;
      logic rsp_busy;
   } status_type;

   // edges are tested in the order 0-1, 1-2, 3-0, 2-3
   function automatic logic [1:0] edge_from(input logic [1:0] e);
      logic [1:0] c;
      unique case (e)
         2'd0: c = 2'd0;
         2'd1: c = 2'd1;
         2'd2: c = 2'd3;
         default: c = 2'd2;
      endcase
      return c;
   endfunction

   function automatic logic [1:0] edge_to(input logic [1:0] e);
      logic [1:0] c;
      unique case (e)
         2'd0: c = 2'd1;
         2'd1: c = 2'd2;
         2'd2: c = 2'd0;
         default: c = 2'd3;
      endcase
      return c;
   endfunction

endpackage

`default_nettype wire

// ----- sv/rrnh_ctrl.sv -----
// sequencer of the ray rectangle nearest hit unit
// depends on rrnh_pkg; drives the datapath through cmd_type commands
`default_nettype none

module rrnh_ctrl
   import rrnh_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_tvalid,
   output logic            req_tready,
   input  status_type      status,
   output cmd_type         cmd
);

   typedef enum logic [4:0] {
      ST_IDLE, ST_START, ST_EDGE, ST_MUL, ST_DEN, ST_CHECK, ST_BRANCH,
      ST_PMUL, ST_PSUM, ST_DIV, ST_POINT, ST_MAG, ST_SQR, ST_SQSUM,
      ST_SQRT, ST_UPDATE, ST_FINISH
   } state_type;

   state_type        state_ff;
   logic [1:0]       edge_ff;
   logic             axis_ff;
   logic [CNT_W-1:0] cnt_ff;

   assign req_tready = (state_ff == ST_IDLE);

   always_comb begin
      cmd.edge_sel = edge_ff;
      cmd.axis = axis_ff;
      unique case (state_ff)
         ST_IDLE:   cmd.op = req_tvalid ? OP_LOAD : OP_NONE;
         ST_EDGE:   cmd.op = OP_EDGE;
         ST_MUL:    cmd.op = OP_MUL;
         ST_DEN:    cmd.op = OP_DEN;
         ST_CHECK:  cmd.op = OP_CHECK;
         ST_PMUL:   cmd.op = OP_PMUL;
         ST_PSUM:   cmd.op = OP_PSUM;
         ST_DIV:    cmd.op = OP_DIV;
         ST_POINT:  cmd.op = OP_POINT;
         ST_MAG:    cmd.op = OP_MAG;
         ST_SQR:    cmd.op = OP_SQR;
         ST_SQSUM:  cmd.op = OP_SQSUM;
         ST_SQRT:   cmd.op = OP_SQRT;
         ST_UPDATE: cmd.op = OP_UPDATE;
         ST_FINISH: cmd.op = status.rsp_busy ? OP_NONE : OP_RESULT;
         default:   cmd.op = OP_NONE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         edge_ff <= '0;
         axis_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         unique case (state_ff)
            ST_IDLE: begin
               edge_ff <= '0;
               axis_ff <= 1'b0;
               if (req_tvalid) state_ff <= ST_START;
            end
            ST_START:  state_ff <= status.solid ? ST_EDGE : ST_FINISH;
            ST_EDGE:   state_ff <= ST_MUL;
            ST_MUL:    state_ff <= ST_DEN;
            ST_DEN:    state_ff <= ST_CHECK;
            ST_CHECK:  state_ff <= ST_BRANCH;
            ST_BRANCH: begin
               axis_ff <= 1'b0;
               if (status.edge_ok) begin
                  state_ff <= ST_PMUL;
               end else if (edge_ff == 2'd3) begin
                  state_ff <= ST_FINISH;
               end else begin
                  edge_ff <= edge_ff + 2'd1;
                  state_ff <= ST_EDGE;
               end
            end
            ST_PMUL: state_ff <= ST_PSUM;
            ST_PSUM: begin
               cnt_ff <= CNT_W'(DIV_STEPS - 1);
               state_ff <= ST_DIV;
            end
            ST_DIV: begin
               if (cnt_ff == '0) begin
                  if (axis_ff) begin
                     state_ff <= ST_POINT;
                  end else begin
                     axis_ff <= 1'b1;
                     state_ff <= ST_PMUL;
                  end
               end else begin
                  cnt_ff <= cnt_ff - 1'b1;
               end
            end
            ST_POINT: state_ff <= ST_MAG;
            ST_MAG:   state_ff <= ST_SQR;
            ST_SQR:   state_ff <= ST_SQSUM;
            ST_SQSUM: begin
               cnt_ff <= CNT_W'(SQRT_STEPS - 1);
               state_ff <= ST_SQRT;
            end
            ST_SQRT: begin
               if (cnt_ff == '0) state_ff <= ST_UPDATE;
               else cnt_ff <= cnt_ff - 1'b1;
            end
            ST_UPDATE: begin
               axis_ff <= 1'b0;
               if (edge_ff == 2'd3) begin
                  state_ff <= ST_FINISH;
               end else begin
                  edge_ff <= edge_ff + 2'd1;
                  state_ff <= ST_EDGE;
               end
            end
            ST_FINISH: if (!status.rsp_busy) state_ff <= ST_IDLE;
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

endmodule

`default_nettype wire

// ----- sv/rrnh_dpath.sv -----
// datapath of the ray rectangle nearest hit unit: registers, multipliers,
// shared divider and square root; depends on rrnh_pkg
`default_nettype none

module rrnh_dpath
   import rrnh_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  csr_we,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [COORD_W-1:0]    csr_wdata,
   input  wire logic [REQ_DATA_W-1:0] req_tdata,
   input  wire logic [REQ_USER_W-1:0] req_tuser,
   input  cmd_type                    cmd,
   output status_type                 status,
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0]      rsp_tdata,
   output logic [RSP_USER_W-1:0]      rsp_tuser
);

   logic signed [COORD_W-1:0] org_x_ff, org_y_ff, thr_x_ff, thr_y_ff;
   logic signed [DIFF_W-1:0]  rx, ry;

   logic                      solid_ff;
   logic [ID_W-1:0]           wall_id_ff;
   logic signed [COORD_W-1:0] cx_ff [4];
   logic signed [COORD_W-1:0] cy_ff [4];
   logic signed [COORD_W-1:0] req_cx [4];
   logic signed [COORD_W-1:0] req_cy [4];

   logic signed [COORD_W-1:0] x1_ff, y1_ff;
   logic signed [DIFF_W-1:0]  ex_ff, ey_ff, qx_ff, qy_ff;
   logic [DIFF_W-1:0]         mdx_ff, mdy_ff;
   logic                      sdx_ff, sdy_ff;
   logic signed [PROD_W-1:0]  p0_ff, p1_ff, p2_ff, p3_ff, p4_ff, p5_ff;
   logic signed [WIDE_W-1:0]  den_ff, tn_ff, un_ff;
   logic                      edge_ok_ff;
   logic [WIDE_W-1:0]         plo_ff;
   logic [PROD_W-1:0]         phi_ff;
   logic [NUM_W-1:0]          rem_ff, dsh_ff;
   logic [QUO_W-1:0]          quo_ff, offx_ff;
   logic signed [COORD_W-1:0] hx_ff, hy_ff;
   logic [DIFF_W-1:0]         mlx_ff, mly_ff;
   logic [PROD_W-1:0]         sqx_ff, sqy_ff;
   logic [RAD_W-1:0]          rad_ff;
   logic [SREM_W-1:0]         srem_ff;
   logic [ROOT_W-1:0]         root_ff;

   logic                      wall_hit_ff, found_ff;
   logic [LEN_W-1:0]          best_len_ff;
   logic [ID_W-1:0]           best_wall_ff;
   logic signed [COORD_W-1:0] best_x_ff, best_y_ff;
   logic                      rsp_valid_ff;
   logic [RSP_DATA_W-1:0]     rsp_data_ff;
   logic [RSP_USER_W-1:0]     rsp_user_ff;

   // edge operands
   logic signed [COORD_W-1:0] ex1, ey1, ex2, ey2;
   logic signed [DIFF_W-1:0]  dx, dy;
   // wide differences, both signs
   logic signed [WIDE_W-1:0]  d_a, d_b, t_a, t_b, u_a, u_b;
   logic [DIFF_W-1:0]         pm;
   logic [NUM_W:0]            div_trial;
   logic signed [DIFF_W:0]    off_x, off_y, sum_x, sum_y;
   logic signed [DIFF_W-1:0]  lx, ly;
   logic [SREM_W+1:0]         sq_cur, sq_try;
   logic [SREM_W+2:0]         sq_diff;
   logic [LEN_W-1:0]          len;

   always_comb begin
      for (int k = 0; k < 4; k++) begin
         req_cx[k] = req_tdata[ID_W + 2*k*COORD_W +: COORD_W];
         req_cy[k] = req_tdata[ID_W + (2*k+1)*COORD_W +: COORD_W];
      end
   end

   assign rx = DIFF_W'(org_x_ff) - DIFF_W'(thr_x_ff);
   assign ry = DIFF_W'(org_y_ff) - DIFF_W'(thr_y_ff);

   assign ex1 = cx_ff[edge_from(cmd.edge_sel)];
   assign ey1 = cy_ff[edge_from(cmd.edge_sel)];
   assign ex2 = cx_ff[edge_to(cmd.edge_sel)];
   assign ey2 = cy_ff[edge_to(cmd.edge_sel)];
   assign dx = DIFF_W'(ex2) - DIFF_W'(ex1);
   assign dy = DIFF_W'(ey2) - DIFF_W'(ey1);

   assign d_a = WIDE_W'(p0_ff) - WIDE_W'(p1_ff);
   assign d_b = WIDE_W'(p1_ff) - WIDE_W'(p0_ff);
   assign t_a = WIDE_W'(p2_ff) - WIDE_W'(p3_ff);
   assign t_b = WIDE_W'(p3_ff) - WIDE_W'(p2_ff);
   assign u_a = WIDE_W'(p5_ff) - WIDE_W'(p4_ff);
   assign u_b = WIDE_W'(p4_ff) - WIDE_W'(p5_ff);

   assign pm = cmd.axis ? mdy_ff : mdx_ff;
   assign div_trial = {1'b0, rem_ff} - {1'b0, dsh_ff};

   // offsets run from the first corner toward the second
   assign off_x = sdx_ff ? -$signed({1'b0, offx_ff}) : $signed({1'b0, offx_ff});
   assign off_y = sdy_ff ? -$signed({1'b0, quo_ff}) : $signed({1'b0, quo_ff});
   assign sum_x = (DIFF_W+1)'(x1_ff) + off_x;
   assign sum_y = (DIFF_W+1)'(y1_ff) + off_y;
   assign lx = DIFF_W'(hx_ff) - DIFF_W'(org_x_ff);
   assign ly = DIFF_W'(hy_ff) - DIFF_W'(org_y_ff);

   // one radicand digit pair per step
   assign sq_cur = {srem_ff, rad_ff[RAD_W-1 -: 2]};
   assign sq_try = (SREM_W+2)'({root_ff, 2'b01});
   assign sq_diff = {1'b0, sq_cur} - {1'b0, sq_try};

   assign len = (|root_ff[ROOT_W-1:LEN_W]) ? '1 : root_ff[LEN_W-1:0];

   assign status.solid = solid_ff;
   assign status.edge_ok = edge_ok_ff;
   assign status.rsp_busy = rsp_valid_ff && !rsp_tready;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = rsp_data_ff;
   assign rsp_tuser = rsp_user_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         org_x_ff <= '0;
         org_y_ff <= '0;
         thr_x_ff <= THROUGH_X_RESET;
         thr_y_ff <= '0;
      end else if (csr_we) begin
         unique case (csr_reg_type'(csr_index))
            REG_ORIGIN_X:  org_x_ff <= csr_wdata;
            REG_ORIGIN_Y:  org_y_ff <= csr_wdata;
            REG_THROUGH_X: thr_x_ff <= csr_wdata;
            REG_THROUGH_Y: thr_y_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.op == OP_RESULT) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.op == OP_RESULT) begin
         rsp_user_ff <= {found_ff, wall_hit_ff};
         rsp_data_ff <= RSP_DATA_W'({best_y_ff, best_x_ff, best_wall_ff, best_len_ff});
      end
   end

   // nearest-hit record
   always_ff @(posedge clock) begin
      if (reset) begin
         found_ff <= 1'b0;
         best_len_ff <= '0;
         best_wall_ff <= '0;
         best_x_ff <= '0;
         best_y_ff <= '0;
         wall_hit_ff <= 1'b0;
      end else if (cmd.op == OP_LOAD) begin
         wall_hit_ff <= 1'b0;
         if (req_tuser[0]) begin
            found_ff <= 1'b0;
            best_len_ff <= '0;
            best_wall_ff <= '0;
            best_x_ff <= '0;
            best_y_ff <= '0;
         end
      end else if (cmd.op == OP_UPDATE) begin
         wall_hit_ff <= 1'b1;
         // equal distance replaces
         if (!found_ff || best_len_ff >= len) begin
            found_ff <= 1'b1;
            best_len_ff <= len;
            best_wall_ff <= wall_id_ff;
            best_x_ff <= hx_ff;
            best_y_ff <= hy_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         solid_ff <= 1'b0;
         edge_ok_ff <= 1'b0;
      end else begin
         case (cmd.op)
            OP_LOAD: solid_ff <= req_tuser[1];
            OP_CHECK: begin
               edge_ok_ff <= (den_ff != '0) && !tn_ff[WIDE_W-1] && (tn_ff != '0)
                             && (tn_ff < den_ff) && !un_ff[WIDE_W-1] && (un_ff != '0);
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      case (cmd.op)
         OP_LOAD: begin
            wall_id_ff <= req_tdata[ID_W-1:0];
            for (int k = 0; k < 4; k++) begin
               cx_ff[k] <= req_cx[k];
               cy_ff[k] <= req_cy[k];
            end
         end
         OP_EDGE: begin
            x1_ff <= ex1;
            y1_ff <= ey1;
            ex_ff <= -dx;
            ey_ff <= -dy;
            qx_ff <= DIFF_W'(ex1) - DIFF_W'(org_x_ff);
            qy_ff <= DIFF_W'(ey1) - DIFF_W'(org_y_ff);
            sdx_ff <= dx[DIFF_W-1];
            sdy_ff <= dy[DIFF_W-1];
            mdx_ff <= dx[DIFF_W-1] ? -dx : dx;
            mdy_ff <= dy[DIFF_W-1] ? -dy : dy;
         end
         OP_MUL: begin
            p0_ff <= ex_ff * ry;
            p1_ff <= ey_ff * rx;
            p2_ff <= qx_ff * ry;
            p3_ff <= qy_ff * rx;
            p4_ff <= ex_ff * qy_ff;
            p5_ff <= ey_ff * qx_ff;
         end
         OP_DEN: begin
            den_ff <= d_a[WIDE_W-1] ? d_b : d_a;
            tn_ff <= d_a[WIDE_W-1] ? t_b : t_a;
            un_ff <= d_a[WIDE_W-1] ? u_b : u_a;
         end
         OP_PMUL: begin
            plo_ff <= WIDE_W'(tn_ff[TLO_W-1:0] * pm);
            phi_ff <= PROD_W'(tn_ff[WIDE_W-1:TLO_W] * pm);
         end
         OP_PSUM: begin
            rem_ff <= NUM_W'({phi_ff, {TLO_W{1'b0}}}) + NUM_W'(plo_ff);
            dsh_ff <= NUM_W'({den_ff, {(QUO_W-1){1'b0}}});
            quo_ff <= '0;
            if (cmd.axis) offx_ff <= quo_ff;
         end
         OP_DIV: begin
            if (!div_trial[NUM_W]) rem_ff <= div_trial[NUM_W-1:0];
            quo_ff <= {quo_ff[QUO_W-2:0], !div_trial[NUM_W]};
            dsh_ff <= dsh_ff >> 1;
         end
         OP_POINT: begin
            hx_ff <= sum_x[COORD_W-1:0];
            hy_ff <= sum_y[COORD_W-1:0];
         end
         OP_MAG: begin
            mlx_ff <= lx[DIFF_W-1] ? -lx : lx;
            mly_ff <= ly[DIFF_W-1] ? -ly : ly;
         end
         OP_SQR: begin
            sqx_ff <= mlx_ff * mlx_ff;
            sqy_ff <= mly_ff * mly_ff;
         end
         OP_SQSUM: begin
            rad_ff <= RAD_W'(sqx_ff) + RAD_W'(sqy_ff);
            srem_ff <= '0;
            root_ff <= '0;
         end
         OP_SQRT: begin
            if (!sq_diff[SREM_W+2]) srem_ff <= sq_diff[SREM_W-1:0];
            else srem_ff <= sq_cur[SREM_W-1:0];
            root_ff <= {root_ff[ROOT_W-2:0], !sq_diff[SREM_W+2]};
            rad_ff <= rad_ff << 2;
         end
         default: ;
      endcase
   end

endmodule

`default_nettype wire

// ----- sv/ray_rectangle_nearest_hit_unit.sv -----
// top level of the ray rectangle nearest hit unit
// depends on rrnh_pkg, rrnh_ctrl and rrnh_dpath
`default_nettype none

// A ray runs from the configured origin through the configured second point.
// Each request beat carries one wall as four corners; for a solid wall the
// edges 0-1, 1-2, 3-0 and 2-3 are intersected with the ray line in turn and
// the nearest hit since the last scan_first beat is kept (equal distances
// replace). Every request beat gives one response beat with the updated
// record. One wall is worked at a time; each edge that is hit goes through
// the shared one-bit-a-step divider (25 steps for x and for y) and the
// two-bit-a-step square root (26 steps). A finished response sits in an
// output register, so the next request is taken while the previous
// response waits. Config registers must only be written while no wall is
// in flight; there is no read-back.

module ray_rectangle_nearest_hit_unit
   import rrnh_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   // config write port
   input  wire logic                  csr_we,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [COORD_W-1:0]    csr_wdata,
   // request channel
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   // wall_id, corner0_x, corner0_y, corner1_x, corner1_y, corner2_x,
   // corner2_y, corner3_x, corner3_y, zero pad
   input  wire logic [REQ_DATA_W-1:0] req_tdata,
   // scan_first, solid
   input  wire logic [REQ_USER_W-1:0] req_tuser,
   // response channel
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   // nearest_length, nearest_wall, nearest_x, nearest_y, zero pad
   output logic [RSP_DATA_W-1:0]      rsp_tdata,
   // wall_hit, any_hit
   output logic [RSP_USER_W-1:0]      rsp_tuser
);

   cmd_type    cmd;
   status_type status;

   // sequencer
   rrnh_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   // arithmetic, record and output register
   rrnh_dpath u_dpath (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .cmd        (cmd),
      .status     (status),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   // without a record every record field reads zero
   a_empty_record: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser[1] |-> rsp_tdata[81:0] == '0)
      else $error("record fields nonzero without a record");

   // a hit on this wall means a record is held
   a_hit_has_record: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[0] |-> rsp_tuser[1])
      else $error("wall hit without record");

   // one wall at a time
   a_one_wall: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("second request taken while busy");

endmodule

`default_nettype wire

// ----- tb/sv/rrnh_nearest_hit_checker.sv -----
// checker for the ray rectangle nearest hit unit: watches config writes, walls and records
// predicts the nearest-hit record per wall beat; depends on rrnh_pkg
`default_nettype none

module rrnh_nearest_hit_checker
   import rrnh_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  csr_we,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [COORD_W-1:0]    csr_wdata,
   input  wire logic                  req_tvalid,
   input  wire logic                  req_tready,
   input  wire logic [REQ_DATA_W-1:0] req_tdata,
   input  wire logic [REQ_USER_W-1:0] req_tuser,
   input  wire logic                  rsp_tvalid,
   input  wire logic                  rsp_tready,
   input  wire logic [RSP_DATA_W-1:0] rsp_tdata,
   input  wire logic [RSP_USER_W-1:0] rsp_tuser,
   output int                         mismatches,
   output int                         records_waiting,
   output int                         wall_hits
);

   typedef logic signed [127:0] wide_type;

   typedef struct packed {
      logic        wall_hit;
      logic        any_hit;
      logic [23:0] length;
      logic [9:0]  wall;
      logic [23:0] px;
      logic [23:0] py;
   } record_type;

   longint org_x, org_y, thr_x, thr_y;
   logic        rec_found;
   logic [23:0] rec_length;
   logic [9:0]  rec_wall;
   longint      rec_x, rec_y;
   record_type  expected_records[$];

   function automatic longint sx24(input logic [23:0] v);
      return longint'(signed'(v));
   endfunction

   function automatic longint magnitude(input longint v);
      return v < 0 ? -v : v;
   endfunction

   // one edge against the ray line; point found by exact floor division
   function automatic bit edge_cross(input longint x1, y1, x2, y2,
                                     output longint hx, hy);
      longint   rx, ry, ex, ey, qx, qy, dx, dy, den, tn, un;
      wide_type ofs_x, ofs_y;
      rx = org_x - thr_x;  ry = org_y - thr_y;
      ex = x1 - x2;        ey = y1 - y2;
      qx = x1 - org_x;     qy = y1 - org_y;
      dx = x2 - x1;        dy = y2 - y1;
      den = ex * ry - ey * rx;
      tn  = qx * ry - qy * rx;
      un  = -(ex * qy - ey * qx);
      hx = 0;
      hy = 0;
      if (den == 0) return 0;
      if (den < 0) begin
         den = -den; tn = -tn; un = -un;
      end
      if (tn <= 0 || tn >= den || un <= 0) return 0;
      ofs_x = (wide_type'(tn) * wide_type'(magnitude(dx))) / wide_type'(den);
      ofs_y = (wide_type'(tn) * wide_type'(magnitude(dy))) / wide_type'(den);
      hx = x1 + (dx < 0 ? -longint'(ofs_x) : longint'(ofs_x));
      hy = y1 + (dy < 0 ? -longint'(ofs_y) : longint'(ofs_y));
      return 1;
   endfunction

   function automatic logic [23:0] hit_distance(input longint hx, hy);
      wide_type sq, root, cand;
      longint   lx, ly;
      lx = hx - org_x;
      ly = hy - org_y;
      sq = wide_type'(lx) * wide_type'(lx) + wide_type'(ly) * wide_type'(ly);
      root = 0;
      for (int b = 40; b >= 0; b--) begin
         cand = root | (wide_type'(1) << b);
         if (cand * cand <= sq) root = cand;
      end
      return root > 128'hFFFFFF ? 24'hFFFFFF : root[23:0];
   endfunction

   // edges in the order 0-1, 1-2, 3-0, 2-3, updating the kept record
   function automatic record_type predict_record(input logic [REQ_USER_W-1:0] u,
                                                 input logic [REQ_DATA_W-1:0] d);
      longint      cx[4], cy[4], hx, hy;
      int          from_c[4], to_c[4];
      logic [23:0] len;
      record_type  r;
      from_c = '{0, 1, 3, 2};
      to_c   = '{1, 2, 0, 3};
      r.wall_hit = 0;
      if (u[0]) begin
         rec_found = 0; rec_length = 0; rec_wall = 0; rec_x = 0; rec_y = 0;
      end
      for (int k = 0; k < 4; k++) begin
         cx[k] = sx24(d[10 + 48*k +: 24]);
         cy[k] = sx24(d[34 + 48*k +: 24]);
      end
      if (u[1]) begin
         for (int k = 0; k < 4; k++) begin
            if (edge_cross(cx[from_c[k]], cy[from_c[k]], cx[to_c[k]], cy[to_c[k]],
                           hx, hy)) begin
               r.wall_hit = 1;
               len = hit_distance(hx, hy);
               if (!rec_found || rec_length >= len) begin
                  rec_found = 1; rec_length = len; rec_wall = d[9:0];
                  rec_x = hx; rec_y = hy;
               end
            end
         end
      end
      r.any_hit = rec_found;
      r.length  = rec_length;
      r.wall    = rec_wall;
      r.px      = rec_x[23:0];
      r.py      = rec_y[23:0];
      return r;
   endfunction

   always @(posedge clock) begin
      record_type want, got;
      if (reset) begin
         org_x = 0; org_y = 0; thr_x = 2560; thr_y = 0;
         rec_found = 0; rec_length = 0; rec_wall = 0; rec_x = 0; rec_y = 0;
         expected_records.delete();
         mismatches = 0;
         wall_hits = 0;
      end else begin
         if (csr_we) begin
            case (csr_reg_type'(csr_index))
               REG_ORIGIN_X:  org_x = sx24(csr_wdata);
               REG_ORIGIN_Y:  org_y = sx24(csr_wdata);
               REG_THROUGH_X: thr_x = sx24(csr_wdata);
               REG_THROUGH_Y: thr_y = sx24(csr_wdata);
               default: ;
            endcase
         end
         if (req_tvalid && req_tready) begin
            want = predict_record(req_tuser, req_tdata);
            if (want.wall_hit) wall_hits++;
            expected_records.push_back(want);
         end
         if (rsp_tvalid && rsp_tready) begin
            got = {rsp_tuser[0], rsp_tuser[1], rsp_tdata[23:0], rsp_tdata[33:24],
                   rsp_tdata[57:34], rsp_tdata[81:58]};
            if (expected_records.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("unexpected record beat %h", got);
            end else begin
               want = expected_records.pop_front();
               if (got !== want) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display(
                        "exp/act hit %b/%b any %b/%b len %h/%h wall %h/%h x %h/%h y %h/%h",
                        want.wall_hit, got.wall_hit, want.any_hit, got.any_hit,
                        want.length, got.length, want.wall, got.wall,
                        want.px, got.px, want.py, got.py);
               end
            end
         end
      end
      records_waiting = expected_records.size();
   end

endmodule

`default_nettype wire

// ----- tb/sv/tb.sv -----
// top of the nearest hit testbench: clock, reset, wall stimulus and verdict
// depends on rrnh_pkg, ray_rectangle_nearest_hit_unit and rrnh_nearest_hit_checker
`default_nettype none

module tb;
   import rrnh_pkg::*;

   logic                  clock;
   logic                  reset;
   logic                  csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [COORD_W-1:0]    csr_wdata;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata;   // wall_id, c0x, c0y, c1x, c1y, c2x, c2y, c3x, c3y, pad
   logic [REQ_USER_W-1:0] req_tuser;   // scan_first, solid
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;   // nearest_length, nearest_wall, nearest_x, nearest_y, pad
   logic [RSP_USER_W-1:0] rsp_tuser;   // wall_hit, any_hit

   int mismatches, records_waiting, wall_hits;
   int cycles;
   int walls_sent;
   int rsp_hold;       // long receiver hold-off requested by the stimulus
   bit req_eager, rsp_eager;
   longint ray_ox, ray_oy, ray_tx, ray_ty;   // stimulus copy of the ray, for aiming walls

   ray_rectangle_nearest_hit_unit dut (.*);

   rrnh_nearest_hit_checker checker_i (.*);

   initial begin
      clock = 0;
      forever #2 clock = ~clock;
   end

   // run limit: past it the run stops and reports mismatches
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > 1500000) begin
         $display("Mismatches found");
         $finish;
      end
   end

   // receiver: random stall per beat, plus the long hold once when asked
   initial begin
      int n;
      bit held;
      held = 0;
      rsp_tready = 0;
      @(negedge reset);
      forever begin
         @(posedge clock);
         if (rsp_hold > 0 && !held) begin
            held = 1;
            n = rsp_hold;
            rsp_tready <= 0;
            repeat (n) @(posedge clock);
         end else begin
            n = rsp_eager ? 0 : $urandom_range(0, 8);
            if (n > 0) begin
               rsp_tready <= 0;
               repeat (n) @(posedge clock);
            end
         end
         rsp_tready <= 1;
         do @(posedge clock); while (!rsp_tvalid);
      end
   end

   function automatic logic [REQ_DATA_W-1:0] wall_beat(input logic [9:0] id,
                                                       input longint c[8]);
      logic [REQ_DATA_W-1:0] d;
      d = '0;
      d[9:0] = id;
      for (int k = 0; k < 8; k++) d[10 + 24*k +: 24] = c[k][23:0];
      return d;
   endfunction

   // rectangle from x0..x1, y0..y1, corners top-left, top-right, bottom-right, bottom-left
   function automatic logic [REQ_DATA_W-1:0] box_beat(input logic [9:0] id,
                                                      input longint x0, y0, x1, y1);
      longint c[8];
      c = '{x0, y1, x1, y1, x1, y0, x0, y0};
      return wall_beat(id, c);
   endfunction

   task automatic send_wall(input logic scan_first, solid, input logic [REQ_DATA_W-1:0] d);
      int gap;
      gap = req_eager ? 0 : $urandom_range(0, 8);
      if (gap > 0) begin
         req_tvalid <= 0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1;
      req_tdata  <= d;
      req_tuser  <= {solid, scan_first};
      do @(posedge clock); while (!req_tready);
      walls_sent++;
   endtask

   task automatic drain;
      req_tvalid <= 0;
      @(posedge clock);
      while (records_waiting != 0) @(posedge clock);
   endtask

   task automatic set_ray(input longint ox, oy, tx, ty);
      longint v[4];
      v = '{ox, oy, tx, ty};
      for (int i = 0; i < 4; i++) begin
         csr_we    <= 1;
         csr_index <= CSR_IDX_W'(i);
         csr_wdata <= v[i][23:0];
         @(posedge clock);
      end
      csr_we <= 0;
      ray_ox = ox; ray_oy = oy; ray_tx = tx; ray_ty = ty;
   endtask

   // mostly rectangles placed along the ray (ahead, behind, offset); some raw noise
   task automatic random_walls(input int count);
      longint px, py, hw, hh, off;
      longint c[8];
      logic [9:0] id;
      for (int i = 0; i < count; i++) begin
         id = 10'($urandom);
         if ($urandom_range(0, 9) < 7) begin
            off = longint'($urandom_range(0, 48)) - 8;
            px = ray_ox + ((ray_tx - ray_ox) * off) / 8;
            py = ray_oy + ((ray_ty - ray_oy) * off) / 8;
            hw = $urandom_range(1, 4096);
            hh = $urandom_range(1, 4096);
            if ($urandom_range(0, 3) == 0) py += longint'($urandom_range(0, 16384)) - 8192;
            send_wall($urandom_range(0, 9) == 0, $urandom_range(0, 9) != 0,
                      box_beat(id, px - hw, py - hh, px + hw, py + hh));
         end else begin
            for (int k = 0; k < 8; k++) c[k] = longint'($urandom);
            send_wall($urandom_range(0, 1), $urandom_range(0, 1), wall_beat(id, c));
         end
      end
   endtask

   initial begin
      longint c[8];
      reset = 1;
      csr_we = 0; csr_index = '0; csr_wdata = '0;
      req_tvalid = 0; req_tdata = '0; req_tuser = '0;
      rsp_hold = 0; req_eager = 0; rsp_eager = 0;
      walls_sent = 0;
      ray_ox = 0; ray_oy = 0; ray_tx = 2560; ray_ty = 0;
      repeat (9) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed walls on the reset ray (origin 0,0 through 10,0)
      send_wall(1, 1, box_beat(10'd1, 1280, -256, 1792, 256));      // hit, new record
      send_wall(0, 1, box_beat(10'd2, 1280, -256, 1792, 256));      // equal distance replaces
      send_wall(0, 1, box_beat(10'd3, 2000, -256, 2200, 256));      // farther, kept
      send_wall(0, 1, box_beat(10'd4, 500, -100, 600, 100));        // nearer, replaces
      send_wall(0, 0, box_beat(10'd5, 100, -100, 200, 100));        // non-solid, skipped
      send_wall(0, 1, box_beat(10'd6, -1792, -256, -1280, 256));    // behind the origin
      send_wall(0, 1, box_beat(10'd7, 300, 300, 400, 400));         // off the line
      c = '{700, 0, 700, 0, 700, 0, 700, 0};
      send_wall(0, 1, wall_beat(10'd8, c));                         // degenerate edges
      send_wall(0, 1, box_beat(10'd1023, -8388608, -8388608, 8388607, 8388607));
      c = '{8388607, -8388608, -8388608, 8388607, 8388607, 8388607, -8388608, -8388608};
      send_wall(0, 1, wall_beat(10'd0, c));                         // crossed extreme edges
      send_wall(1, 0, box_beat(10'h3FF, 0, 0, 0, 0));               // clear, no record
      send_wall(0, 1, box_beat(10'd9, 2560, -1, 2562, 1));          // on the through point
      drain();

      // degenerate ray: nothing can hit
      set_ray(1000, -1000, 1000, -1000);
      send_wall(1, 1, box_beat(10'd10, 900, -1100, 1100, -900));
      send_wall(0, 1, box_beat(10'd11, -8388608, -8388608, 8388607, 8388607));
      drain();

      // extremes of the ray registers
      set_ray(-8388608, -8388608, 8388607, 8388607);
      send_wall(1, 1, box_beat(10'd12, -4096, -4096, 4096, 4096));
      send_wall(0, 1, box_beat(10'd13, 8388000, 8388000, 8388607, 8388607));
      random_walls(60);
      drain();

      // diagonal ray; receiver holds off long while walls keep coming
      set_ray(-5000, 3000, 2000, -1500);
      rsp_hold = 800;
      random_walls(160);
      drain();

      // back-to-back stretch with no idling on either side
      set_ray(0, 0, 2560, 0);
      req_eager = 1; rsp_eager = 1;
      random_walls(120);
      drain();
      req_eager = 0; rsp_eager = 0;

      // random rays of modest size
      for (int p = 0; p < 3; p++) begin
         set_ray(longint'($urandom_range(0, 2097152)) - 1048576,
                 longint'($urandom_range(0, 2097152)) - 1048576,
                 longint'($urandom_range(0, 2097152)) - 1048576,
                 longint'($urandom_range(0, 2097152)) - 1048576);
         random_walls(110);
         drain();
      end

      req_tvalid <= 0;
      while (records_waiting != 0) @(posedge clock);
      repeat (400) @(posedge clock);

      $display("covered %0d wall beats over several ray settings, %0d of them hit",
               walls_sent, wall_hits);
      if (mismatches == 0 && records_waiting == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule

`default_nettype wire

// ----- sim.f -----
sv/rrnh_pkg.sv
sv/rrnh_ctrl.sv
sv/rrnh_dpath.sv
sv/ray_rectangle_nearest_hit_unit.sv
tb/sv/rrnh_nearest_hit_checker.sv
tb/sv/tb.sv
